// ===== src/ptob_pkg.sv =====
// ----------------------------------------------------------------------------
// ptob_pkg
// Shared codes, defaults and controller/datapath interface types for the
// price-time order book.
// ----------------------------------------------------------------------------
`default_nettype none

package ptob_pkg;

  localparam int DEF_MAX_ORDERS   = 1024;
  localparam int DEF_PRICE_LEVELS = 4096;

  // request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_FIND   = 3'd2;
  localparam logic [2:0] REQ_BEST   = 3'd3;
  localparam logic [2:0] REQ_FRONT  = 3'd4;
  localparam logic [2:0] REQ_LQTY   = 3'd5;
  localparam logic [2:0] REQ_FILL   = 3'd6;
  localparam logic [2:0] REQ_SETREM = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic       clr;        // clearing pass step
    logic       accept;     // latch request
    logic       cnt_clr;    // restart counter and search flags
    logic       scan;       // slot search step
    logic       best;       // level search step
    logic       ld_s_free;
    logic       ld_s_found;
    logic       ld_s_head;
    logic       ld_lv_req;
    logic       ld_lv_slot;
    logic       sl_cap;
    logic       lv_cap;
    logic       ins_wr;
    logic       ins_link;
    logic       unlink_wr;
    logic       fill_wr;
    logic       setr_wr;
    logic       finish;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       scan_last;
    logic       best_last;
    logic       price_ok;
    logic [2:0] req_type;
    logic       found;
    logic       free_found;
    logic       best_found;
    logic       occ;
    logic       fill_over;
    logic       fill_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/ptob_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptob_ctrl
// Request sequencer: walks each request through search, read, and write
// steps of the datapath and issues one result strobe per request.
// ----------------------------------------------------------------------------
`default_nettype none

module ptob_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output logic                done,
  input  wire ptob_pkg::sts_t sts,
  output ptob_pkg::cmd_t      cmd
);
  import ptob_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN, S_SCAN_DRAIN, S_SCAN_END,
    S_SL_WAIT, S_SL_CAP, S_SL_DEC, S_LV_WAIT, S_LV_CAP, S_LV_DEC,
    S_INS_WR, S_INS_LINK, S_UNLINK_WR, S_FILL_WR, S_SETR_WR,
    S_BEST, S_BEST_DRAIN, S_BEST_END, S_RESP
  } state_t;

  state_t     state, state_next;
  logic [1:0] rsp_status, rsp_status_next;

  always_comb begin
    state_next      = state;
    rsp_status_next = rsp_status;
    cmd             = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.cnt_clr = 1'b1;
        case (sts.req_type)
          REQ_INSERT: begin
            if (!sts.price_ok) begin
              state_next      = S_RESP;
              rsp_status_next = ST_INVALID;
            end else begin
              state_next = S_SCAN;
            end
          end
          REQ_BEST: state_next = S_BEST;
          REQ_FRONT, REQ_LQTY, REQ_FILL: begin
            if (!sts.price_ok) begin
              state_next      = S_RESP;
              rsp_status_next = ST_INVALID;
            end else begin
              cmd.ld_lv_req = 1'b1;
              state_next    = S_LV_WAIT;
            end
          end
          default: state_next = S_SCAN;
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_SCAN_DRAIN;
      end
      S_SCAN_DRAIN: state_next = S_SCAN_END;
      S_SCAN_END: begin
        if (sts.req_type == REQ_INSERT) begin
          if (sts.found) begin
            state_next      = S_RESP;
            rsp_status_next = ST_INVALID;
          end else if (!sts.free_found) begin
            state_next      = S_RESP;
            rsp_status_next = ST_FULL;
          end else begin
            cmd.ld_s_free = 1'b1;
            cmd.ld_lv_req = 1'b1;
            state_next    = S_LV_WAIT;
          end
        end else if (!sts.found) begin
          state_next      = S_RESP;
          rsp_status_next = ST_INVALID;
        end else begin
          cmd.ld_s_found = 1'b1;
          state_next     = S_SL_WAIT;
        end
      end
      S_SL_WAIT: state_next = S_SL_CAP;
      S_SL_CAP: begin
        cmd.sl_cap = 1'b1;
        state_next = S_SL_DEC;
      end
      S_SL_DEC: begin
        case (sts.req_type)
          REQ_REMOVE, REQ_SETREM: begin
            cmd.ld_lv_slot = 1'b1;
            state_next     = S_LV_WAIT;
          end
          REQ_FILL: begin
            if (sts.fill_over) begin
              state_next      = S_RESP;
              rsp_status_next = ST_INVALID;
            end else begin
              state_next = S_FILL_WR;
            end
          end
          default: begin
            state_next      = S_RESP;
            rsp_status_next = ST_OK;
          end
        endcase
      end
      S_LV_WAIT: state_next = S_LV_CAP;
      S_LV_CAP: begin
        cmd.lv_cap = 1'b1;
        state_next = S_LV_DEC;
      end
      S_LV_DEC: begin
        case (sts.req_type)
          REQ_INSERT: state_next = S_INS_WR;
          REQ_REMOVE: state_next = S_UNLINK_WR;
          REQ_SETREM: state_next = S_SETR_WR;
          REQ_FRONT, REQ_FILL: begin
            if (!sts.occ) begin
              state_next      = S_RESP;
              rsp_status_next = ST_INVALID;
            end else begin
              cmd.ld_s_head = 1'b1;
              state_next    = S_SL_WAIT;
            end
          end
          default: begin
            state_next      = S_RESP;
            rsp_status_next = sts.occ ? ST_OK : ST_INVALID;
          end
        endcase
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        if (sts.occ) begin
          state_next = S_INS_LINK;
        end else begin
          state_next      = S_RESP;
          rsp_status_next = ST_OK;
        end
      end
      S_INS_LINK: begin
        cmd.ins_link    = 1'b1;
        state_next      = S_RESP;
        rsp_status_next = ST_OK;
      end
      S_UNLINK_WR: begin
        cmd.unlink_wr   = 1'b1;
        state_next      = S_RESP;
        rsp_status_next = ST_OK;
      end
      S_FILL_WR: begin
        cmd.fill_wr     = 1'b1;
        rsp_status_next = ST_OK;
        // front order used up: take it out of the level
        state_next      = sts.fill_zero ? S_UNLINK_WR : S_RESP;
      end
      S_SETR_WR: begin
        cmd.setr_wr     = 1'b1;
        state_next      = S_RESP;
        rsp_status_next = ST_OK;
      end
      S_BEST: begin
        cmd.best = 1'b1;
        if (sts.best_last) state_next = S_BEST_DRAIN;
      end
      S_BEST_DRAIN: state_next = S_BEST_END;
      S_BEST_END: begin
        state_next      = S_RESP;
        rsp_status_next = sts.best_found ? ST_OK : ST_INVALID;
      end
      S_RESP: begin
        cmd.finish = 1'b1;
        cmd.status = rsp_status;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      busy       <= 1'b1;
      done       <= 1'b0;
      rsp_status <= ST_OK;
    end else begin
      state      <= state_next;
      busy       <= (state_next != S_IDLE);
      done       <= (state == S_RESP);
      rsp_status <= rsp_status_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/ptob_datapath.sv =====
// ----------------------------------------------------------------------------
// ptob_datapath
// Order slot and price level memories, search counters, working registers
// and result registers of the order book.
// ----------------------------------------------------------------------------
`default_nettype none

module ptob_datapath #(
  parameter int MAX_ORDERS   = ptob_pkg::DEF_MAX_ORDERS,
  parameter int PRICE_LEVELS = ptob_pkg::DEF_PRICE_LEVELS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ptob_pkg::cmd_t cmd,
  output ptob_pkg::sts_t      sts,
  input  wire logic [2:0]     req_type,
  input  wire logic [31:0]    order_id,
  input  wire logic           side,
  input  wire logic [11:0]    price,
  input  wire logic [31:0]    quantity,
  output logic [1:0]          status,
  output logic [31:0]         out_order_id,
  output logic                out_side,
  output logic [11:0]         out_price,
  output logic [31:0]         out_remaining,
  output logic [41:0]         out_level_total
);
  import ptob_pkg::*;

  localparam int NLV   = 2 * PRICE_LEVELS;
  localparam int SW    = $clog2(MAX_ORDERS);
  localparam int LW    = $clog2(NLV);
  localparam int PLW   = $clog2(PRICE_LEVELS);
  localparam int TW    = 32 + SW;
  localparam int CLR_N = (MAX_ORDERS > NLV) ? MAX_ORDERS : NLV;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [SW:0]  NIL     = {1'b1, {SW{1'b0}}};
  localparam logic [41:0]  TOT_MAX = '1;

  function automatic logic [LW-1:0] lvl_idx(input logic sd, input logic [31:0] pr);
    lvl_idx = LW'(pr) + (sd ? LW'(PRICE_LEVELS) : {LW{1'b0}});
  endfunction

  // memories
  logic [31:0]   slot_id_mem    [MAX_ORDERS];
  logic          slot_valid_mem [MAX_ORDERS];
  logic [12:0]   slot_sp_mem    [MAX_ORDERS];
  logic [31:0]   slot_rem_mem   [MAX_ORDERS];
  logic [SW:0]   slot_prev_mem  [MAX_ORDERS];
  logic [SW:0]   slot_next_mem  [MAX_ORDERS];
  logic [SW-1:0] lvl_head_mem   [NLV];
  logic [SW-1:0] lvl_tail_mem   [NLV];
  logic [TW-1:0] lvl_total_mem  [NLV];
  logic          lvl_occ_mem    [NLV];

  logic [31:0]   slot_id_q, slot_rem_q;
  logic          slot_valid_q, lvl_occ_q;
  logic [12:0]   slot_sp_q;
  logic [SW:0]   slot_prev_q, slot_next_q;
  logic [SW-1:0] lvl_head_q, lvl_tail_q;
  logic [TW-1:0] lvl_total_q;

  // request
  logic [2:0]  rq_type;
  logic [31:0] rq_id, rq_qty;
  logic        rq_side;
  logic [11:0] rq_price;
  logic        price_ok;
  logic [LW-1:0] rq_lv;

  // working registers
  logic [CW-1:0] cnt;
  logic [SW-1:0] s_cur;
  logic [LW-1:0] lv_cur;
  logic          sp_v, found, free_found;
  logic [SW-1:0] sp_idx, found_s, free_s;
  logic          bp_v, best_found;
  logic [PLW-1:0] bp_p;
  logic [11:0]   best_p;
  logic [31:0]   sd_id, sd_rem;
  logic [12:0]   sd_sp;
  logic [SW:0]   sd_prev, sd_next;
  logic          lv_occ;
  logic [SW-1:0] lv_head, lv_tail;
  logic [TW-1:0] lv_total;

  logic [PLW-1:0] best_pr;
  logic [LW-1:0]  best_lv;
  logic [SW-1:0]  slot_raddr;
  logic [LW-1:0]  lvl_raddr;
  logic [63:0]    tot64;

  assign price_ok   = 32'(rq_price) < 32'(PRICE_LEVELS);
  assign rq_lv      = lvl_idx(rq_side, 32'(rq_price));
  // bids search from the top of the book, asks from the bottom
  assign best_pr    = rq_side ? cnt[PLW-1:0] : PLW'(PRICE_LEVELS - 1) - cnt[PLW-1:0];
  assign best_lv    = lvl_idx(rq_side, 32'(best_pr));
  assign slot_raddr = cmd.scan ? cnt[SW-1:0] : s_cur;
  assign lvl_raddr  = cmd.best ? best_lv : lv_cur;
  assign tot64      = 64'(lv_total);

  assign sts.clr_last   = (cnt == CW'(CLR_N - 1));
  assign sts.scan_last  = (cnt == CW'(MAX_ORDERS - 1));
  assign sts.best_last  = (cnt == CW'(PRICE_LEVELS - 1));
  assign sts.price_ok   = price_ok;
  assign sts.req_type   = rq_type;
  assign sts.found      = found;
  assign sts.free_found = free_found;
  assign sts.best_found = best_found;
  assign sts.occ        = lv_occ;
  assign sts.fill_over  = rq_qty > sd_rem;
  assign sts.fill_zero  = rq_qty == sd_rem;

  // slot memories
  always_ff @(posedge clk) begin
    slot_id_q   <= slot_id_mem[slot_raddr];
    slot_sp_q   <= slot_sp_mem[slot_raddr];
    slot_rem_q  <= slot_rem_mem[slot_raddr];
    slot_prev_q <= slot_prev_mem[slot_raddr];
    slot_next_q <= slot_next_mem[slot_raddr];
    if (cmd.ins_wr) begin
      slot_id_mem[s_cur] <= rq_id;
      slot_sp_mem[s_cur] <= {rq_side, rq_price};
    end
    if (cmd.ins_wr || cmd.setr_wr) begin
      slot_rem_mem[s_cur] <= rq_qty;
    end else if (cmd.fill_wr) begin
      slot_rem_mem[s_cur] <= sd_rem - rq_qty;
    end
    if (cmd.ins_wr) begin
      slot_prev_mem[s_cur] <= lv_occ ? {1'b0, lv_tail} : NIL;
    end else if (cmd.unlink_wr && !sd_next[SW]) begin
      slot_prev_mem[sd_next[SW-1:0]] <= sd_prev;
    end
    if (cmd.ins_wr) begin
      slot_next_mem[s_cur] <= NIL;
    end else if (cmd.ins_link) begin
      slot_next_mem[lv_tail] <= {1'b0, s_cur};
    end else if (cmd.unlink_wr && !sd_prev[SW]) begin
      slot_next_mem[sd_prev[SW-1:0]] <= sd_next;
    end
  end

  always_ff @(posedge clk) begin
    slot_valid_q <= slot_valid_mem[slot_raddr];
    if (cmd.clr && (32'(cnt) < 32'(MAX_ORDERS))) begin
      slot_valid_mem[cnt[SW-1:0]] <= 1'b0;
    end else if (cmd.ins_wr) begin
      slot_valid_mem[s_cur] <= 1'b1;
    end else if (cmd.unlink_wr) begin
      slot_valid_mem[s_cur] <= 1'b0;
    end
  end

  // level memories
  always_ff @(posedge clk) begin
    lvl_head_q  <= lvl_head_mem[lvl_raddr];
    lvl_tail_q  <= lvl_tail_mem[lvl_raddr];
    lvl_total_q <= lvl_total_mem[lvl_raddr];
    if (cmd.ins_wr && !lv_occ) begin
      lvl_head_mem[lv_cur] <= s_cur;
    end else if (cmd.unlink_wr && sd_prev[SW]) begin
      lvl_head_mem[lv_cur] <= sd_next[SW-1:0];
    end
    if (cmd.ins_wr) begin
      lvl_tail_mem[lv_cur] <= s_cur;
    end else if (cmd.unlink_wr && sd_next[SW]) begin
      lvl_tail_mem[lv_cur] <= sd_prev[SW-1:0];
    end
    if (cmd.ins_wr) begin
      lvl_total_mem[lv_cur] <= lv_occ ? lv_total + TW'(rq_qty) : TW'(rq_qty);
    end else if (cmd.fill_wr) begin
      lvl_total_mem[lv_cur] <= lv_total - TW'(rq_qty);
    end else if (cmd.unlink_wr) begin
      lvl_total_mem[lv_cur] <= lv_total - TW'(sd_rem);
    end else if (cmd.setr_wr) begin
      lvl_total_mem[lv_cur] <= lv_total - TW'(sd_rem) + TW'(rq_qty);
    end
  end

  always_ff @(posedge clk) begin
    lvl_occ_q <= lvl_occ_mem[lvl_raddr];
    if (cmd.clr && (32'(cnt) < 32'(NLV))) begin
      lvl_occ_mem[cnt[LW-1:0]] <= 1'b0;
    end else if (cmd.ins_wr) begin
      lvl_occ_mem[lv_cur] <= 1'b1;
    end else if (cmd.unlink_wr && sd_prev[SW] && sd_next[SW]) begin
      lvl_occ_mem[lv_cur] <= 1'b0;
    end
  end

  // control flags and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      sp_v       <= 1'b0;
      bp_v       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.clr || cmd.scan || cmd.best) begin
        cnt <= cnt + 1'b1;
      end
      sp_v <= cmd.scan;
      bp_v <= cmd.best;
      if (cmd.cnt_clr) begin
        found      <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
      end else begin
        if (sp_v && slot_valid_q && (slot_id_q == rq_id)) found <= 1'b1;
        if (sp_v && !slot_valid_q) free_found <= 1'b1;
        if (bp_v && lvl_occ_q) best_found <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sp_idx <= cnt[SW-1:0];
    bp_p   <= best_pr;
    if (sp_v && slot_valid_q && (slot_id_q == rq_id)) found_s <= sp_idx;
    if (sp_v && !slot_valid_q && !free_found) free_s <= sp_idx;
    if (bp_v && lvl_occ_q && !best_found) best_p <= 12'(bp_p);
    if (cmd.accept) begin
      rq_type  <= req_type;
      rq_id    <= order_id;
      rq_side  <= side;
      rq_price <= price;
      rq_qty   <= quantity;
    end
    if (cmd.ld_s_free) begin
      s_cur <= free_s;
    end else if (cmd.ld_s_found) begin
      s_cur <= found_s;
    end else if (cmd.ld_s_head) begin
      s_cur <= lv_head;
    end
    if (cmd.ld_lv_req) begin
      lv_cur <= rq_lv;
    end else if (cmd.ld_lv_slot) begin
      lv_cur <= lvl_idx(sd_sp[12], 32'(sd_sp[11:0]));
    end
    if (cmd.sl_cap) begin
      sd_id   <= slot_id_q;
      sd_sp   <= slot_sp_q;
      sd_rem  <= slot_rem_q;
      sd_prev <= slot_prev_q;
      sd_next <= slot_next_q;
    end else if (cmd.fill_wr) begin
      sd_rem <= sd_rem - rq_qty;
    end
    if (cmd.lv_cap) begin
      lv_occ   <= lvl_occ_q;
      lv_head  <= lvl_head_q;
      lv_tail  <= lvl_tail_q;
      lv_total <= lvl_total_q;
    end else if (cmd.fill_wr) begin
      lv_total <= lv_total - TW'(rq_qty);
    end
    if (cmd.finish) begin
      status          <= cmd.status;
      out_order_id    <= '0;
      out_side        <= 1'b0;
      out_price       <= '0;
      out_remaining   <= '0;
      out_level_total <= '0;
      if (cmd.status == ST_OK) begin
        case (rq_type)
          REQ_FIND: begin
            out_order_id  <= sd_id;
            out_side      <= sd_sp[12];
            out_price     <= sd_sp[11:0];
            out_remaining <= sd_rem;
          end
          REQ_FRONT: begin
            out_order_id  <= sd_id;
            out_side      <= rq_side;
            out_price     <= rq_price;
            out_remaining <= sd_rem;
          end
          REQ_BEST: out_price <= best_p;
          REQ_LQTY: out_level_total <= (tot64 > 64'(TOT_MAX)) ? TOT_MAX : tot64[41:0];
          default: out_price <= '0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/price_time_order_book_unit.sv =====
// ----------------------------------------------------------------------------
// price_time_order_book_unit
// Two-sided limit order book with price-time priority, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and it must be taken then: the
// receiver cannot stall. Requests by id (insert, remove, find, set remaining)
// scan every order slot, one per cycle. Best price scans the levels of one
// side, one per cycle. Level total, front and fill front read their level
// without a scan; insert, front, level total and fill front with a price
// outside the book are answered invalid without a search. busy is low while
// done is high, so the next request can be taken at the edge that takes the
// result. After reset the block clears its valid and occupied memories with
// busy held high.
`default_nettype none

module price_time_order_book_unit #(
  parameter int MAX_ORDERS   = ptob_pkg::DEF_MAX_ORDERS,
  parameter int PRICE_LEVELS = ptob_pkg::DEF_PRICE_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] order_id,
  input  wire logic        side,
  input  wire logic [11:0] price,
  input  wire logic [31:0] quantity,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      out_order_id,
  output logic             out_side,
  output logic [11:0]      out_price,
  output logic [31:0]      out_remaining,
  output logic [41:0]      out_level_total
);
  import ptob_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptob_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  ptob_datapath #(
    .MAX_ORDERS   (MAX_ORDERS),
    .PRICE_LEVELS (PRICE_LEVELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (req_type),
    .order_id        (order_id),
    .side            (side),
    .price           (price),
    .quantity        (quantity),
    .status          (status),
    .out_order_id    (out_order_id),
    .out_side        (out_side),
    .out_price       (out_price),
    .out_remaining   (out_remaining),
    .out_level_total (out_level_total)
  );

endmodule

`default_nettype wire
